FILE: design/gpsel_pkg.sv
`timescale 1ns / 1ps

package gpsel_pkg;

   localparam int MAX_LEN_DEFAULT    = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int GROUP_LENGTH_W = 11;
   localparam int PERCENTILE_W   = 14;
   localparam int ROUNDING_W     = 2;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 14;

   localparam logic [PERCENTILE_W-1:0] Q_FULL      = 14'd10000;
   localparam logic [PERCENTILE_W-1:0] Q_HALF      = 14'd5000;
   localparam logic [PERCENTILE_W-1:0] Q_CEIL_BIAS = 14'd9999;

   localparam logic [GROUP_LENGTH_W-1:0] GROUP_LENGTH_RESET = 11'd1;
   localparam logic [PERCENTILE_W-1:0]   PERCENTILE_RESET   = 14'd5000;

   typedef enum logic [ROUNDING_W-1:0] {
      RND_LOWER   = 2'd0,
      RND_HIGHER  = 2'd1,
      RND_NEAREST = 2'd2,
      RND_UNUSED  = 2'd3
   } rounding_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GROUP_LENGTH  = 2'd0,
      CSR_PERCENTILE_Q  = 2'd1,
      CSR_ROUNDING_MODE = 2'd2,
      CSR_NONE          = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_BIAS,
      ST_DIV,
      ST_RANK,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic req_stall;
      logic ram_write;
      logic rd_issue;
      logic pass_done;
      logic out_load;
   } ctrl_type;

endpackage

FILE: design/gpsel_ram.sv
`timescale 1ns / 1ps

module gpsel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_enable,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/group_percentile_select_unit.sv
`timescale 1ns / 1ps
// A sample that does not complete a group is taken while idle, one sample per cycle. After a
// completing sample the input stalls through the multiply, bias, divide, rank and scan steps,
// and in the finish step while the previous result waits in a stalled output register. One
// shared multiplier forms the rank product and then divides by 10000 through a reciprocal, and
// a radix select reads the sample memory once per key bit. The result waits in an output register,
// so new samples are taken while it is stalled. Synchronous reset clears state, CSRs, fill and valid flags.

module group_percentile_select_unit #(
   parameter int MAX_LEN    = gpsel_pkg::MAX_LEN_DEFAULT,
   parameter int DATA_WIDTH = gpsel_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [DATA_WIDTH-1:0]          req_sample_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [DATA_WIDTH-1:0]          rsp_percentile_value,
   input  logic                                  csr_write_enable,
   input  logic [gpsel_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gpsel_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   import gpsel_pkg::*;

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int CMP_W  = (LEN_W > GROUP_LENGTH_W) ? LEN_W : GROUP_LENGTH_W;
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int PROD_W = LEN_W + PERCENTILE_W;
   localparam int DIVD_W = PROD_W + 1;
   localparam int BIT_W  = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

   localparam int              Q_SHIFT = 4;
   localparam longint unsigned Q_ODD   = 64'(Q_FULL >> Q_SHIFT);
   localparam int              YW      = DIVD_W - Q_SHIFT;
   localparam int              RW      = YW + 1;
   localparam int              RS      = YW + 10;
   localparam int              MUL_W   = YW + RW;
   localparam logic [RW-1:0]   RECIP   = RW'(((64'd1 << RS) + Q_ODD - 64'd1) / Q_ODD);

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic [GROUP_LENGTH_W-1:0] group_length_ff, group_length_in;
   logic [PERCENTILE_W-1:0]   percentile_q_ff, percentile_q_in;
   logic [ROUNDING_W-1:0]     rounding_mode_ff, rounding_mode_in;

   logic [LEN_W-1:0]        fill_ff, fill_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        n_ff, n_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [DIVD_W-1:0]       divq_ff, divq_in;
   logic [LEN_W-1:0]        rank_ff, rank_in;
   logic [LEN_W-1:0]        addr_ff, addr_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [LEN_W-1:0]        cnt_ff, cnt_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic [DATA_WIDTH-1:0]   prefix_ff, prefix_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]   rsp_data_ff, rsp_data_in;

   logic [CMP_W-1:0]        gl_ext;
   logic [LEN_W-1:0]        len_eff;
   logic                    group_last;
   logic [LEN_W-1:0]        slot;
   logic [PERCENTILE_W-1:0] q_clamped;
   logic [PERCENTILE_W-1:0] round_bias;
   logic [YW-1:0]           mul_a;
   logic [RW-1:0]           mul_b;
   logic [MUL_W-1:0]        mul_p;
   logic [DIVD_W-1:0]       offset_raw;
   logic [LEN_W-1:0]        offset_clamped;
   logic [DATA_WIDTH-1:0]   ram_rd_data;
   logic [DATA_WIDTH-1:0]   key;
   logic [DATA_WIDTH-1:0]   hi_mask;
   logic                    key_match;
   logic                    bit_one;
   logic                    req_accept;

   gpsel_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_LEN),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock    (clock),
      .wr_enable(ctrl.ram_write),
      .wr_addr  (slot[ADDR_W-1:0]),
      .wr_data  (req_sample_value),
      .rd_addr  (addr_ff[ADDR_W-1:0]),
      .rd_data  (ram_rd_data)
   );

   always_comb begin
      gl_ext = CMP_W'(group_length_ff);
      if (gl_ext == '0) begin
         len_eff = LEN_W'(1);
      end else if (gl_ext > CMP_W'(MAX_LEN)) begin
         len_eff = LEN_W'(MAX_LEN);
      end else begin
         len_eff = LEN_W'(gl_ext);
      end
      group_last = (fill_ff >= len_eff - LEN_W'(1));
      slot       = group_last ? (len_eff - LEN_W'(1)) : fill_ff;
      req_accept = req_valid && !ctrl.req_stall;

      q_clamped = (percentile_q_ff > Q_FULL) ? Q_FULL : percentile_q_ff;
      case (rounding_mode_ff)
         RND_LOWER:   round_bias = Q_CEIL_BIAS;
         RND_HIGHER:  round_bias = '0;
         RND_NEAREST: round_bias = Q_HALF;
         default:     round_bias = '0;
      endcase

      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         mul_a = YW'(n_ff);
         mul_b = RW'(Q_FULL - q_clamped);
      end else if (state_ff == ST_DIV) begin
         mul_a = divq_ff[DIVD_W-1:Q_SHIFT];
         mul_b = RECIP;
      end
      mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

      offset_raw = (rounding_mode_ff == RND_UNUSED) ? '0 : divq_ff;
      offset_clamped = (offset_raw > DIVD_W'(n_ff)) ? n_ff : LEN_W'(offset_raw);

      key       = {~ram_rd_data[DATA_WIDTH-1], ram_rd_data[DATA_WIDTH-2:0]};
      hi_mask   = ({DATA_WIDTH{1'b1}} << bit_ff) << 1;
      key_match = (((key ^ prefix_ff) & hi_mask) == '0) && !key[bit_ff];
      bit_one   = (rank_ff >= cnt_ff);
   end

   always_comb begin
      ctrl.req_stall = (state_ff != ST_IDLE);
      ctrl.ram_write = (state_ff == ST_IDLE) && req_valid;
      ctrl.rd_issue  = (state_ff == ST_SCAN) && (addr_ff < len_ff);
      ctrl.pass_done = (state_ff == ST_SCAN) && (addr_ff == len_ff) && !rd_vld_ff;
      ctrl.out_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && group_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_BIAS;
         ST_BIAS: state_in = ST_DIV;
         ST_DIV:  state_in = ST_RANK;
         ST_RANK: state_in = ST_SCAN;
         ST_SCAN: begin
            if (ctrl.pass_done && (bit_ff == '0)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (ctrl.out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      group_length_in  = group_length_ff;
      percentile_q_in  = percentile_q_ff;
      rounding_mode_in = rounding_mode_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_GROUP_LENGTH:  group_length_in  = csr_write_data[GROUP_LENGTH_W-1:0];
            CSR_PERCENTILE_Q:  percentile_q_in  = csr_write_data[PERCENTILE_W-1:0];
            CSR_ROUNDING_MODE: rounding_mode_in = csr_write_data[ROUNDING_W-1:0];
            default:           ;
         endcase
      end

      fill_in      = fill_ff;
      len_in       = len_ff;
      n_in         = n_ff;
      prod_in      = prod_ff;
      divq_in      = divq_ff;
      rank_in      = rank_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      prefix_in    = prefix_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (group_last) begin
                  fill_in = '0;
                  len_in  = len_eff;
                  n_in    = len_eff - LEN_W'(1);
               end else begin
                  fill_in = slot + LEN_W'(1);
               end
            end
         end
         ST_MUL: begin
            prod_in = PROD_W'(mul_p);
         end
         ST_BIAS: begin
            divq_in = DIVD_W'(prod_ff) + DIVD_W'(round_bias);
         end
         ST_DIV: begin
            divq_in = DIVD_W'(mul_p[MUL_W-1:RS]);
         end
         ST_RANK: begin
            rank_in   = n_ff - offset_clamped;
            addr_in   = '0;
            cnt_in    = '0;
            bit_in    = BIT_W'(DATA_WIDTH - 1);
            prefix_in = '0;
         end
         ST_SCAN: begin
            if (ctrl.rd_issue) begin
               addr_in = addr_ff + LEN_W'(1);
            end
            rd_vld_in = ctrl.rd_issue;
            if (rd_vld_ff && key_match) begin
               cnt_in = cnt_ff + LEN_W'(1);
            end
            if (ctrl.pass_done) begin
               prefix_in[bit_ff] = bit_one;
               if (bit_one) begin
                  rank_in = rank_ff - cnt_ff;
               end
               cnt_in  = '0;
               addr_in = '0;
               if (bit_ff != '0) begin
                  bit_in = bit_ff - BIT_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (ctrl.out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {~prefix_ff[DATA_WIDTH-1], prefix_ff[DATA_WIDTH-2:0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         group_length_ff  <= GROUP_LENGTH_RESET;
         percentile_q_ff  <= PERCENTILE_RESET;
         rounding_mode_ff <= RND_NEAREST;
         fill_ff          <= '0;
         rd_vld_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         group_length_ff  <= group_length_in;
         percentile_q_ff  <= percentile_q_in;
         rounding_mode_ff <= rounding_mode_in;
         fill_ff          <= fill_in;
         rd_vld_ff        <= rd_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      n_ff        <= n_in;
      prod_ff     <= prod_in;
      divq_ff     <= divq_in;
      rank_ff     <= rank_in;
      addr_ff     <= addr_in;
      cnt_ff      <= cnt_in;
      bit_ff      <= bit_in;
      prefix_ff   <= prefix_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall            = ctrl.req_stall;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_percentile_value = rsp_data_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");

   a_addr_in_group: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (addr_ff <= len_ff))
      else $error("scan address beyond the group");

   a_rank_in_group: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rank_ff < len_ff))
      else $error("remaining rank outside the group");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= addr_ff))
      else $error("match count exceeds reads issued");

   a_div_to_rank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (state_ff == ST_RANK))
      else $error("divider did not hand over to the rank step");

endmodule

FILE: tb/gpsel_checker.sv
`timescale 1ns / 1ps

module gpsel_checker (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   input  logic                                         req_stall,
   input  logic signed [gpsel_pkg::DATA_WIDTH_DEFAULT-1:0] req_sample_value,
   input  logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   input  logic signed [gpsel_pkg::DATA_WIDTH_DEFAULT-1:0] rsp_percentile_value,
   input  logic                                         csr_write_enable,
   input  logic [gpsel_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic [gpsel_pkg::CSR_DATA_W-1:0]             csr_write_data,
   output int                                           mismatch_count,
   output int                                           results_pending
);

   import gpsel_pkg::*;

   localparam int DW           = DATA_WIDTH_DEFAULT;
   localparam int MAX_LEN      = MAX_LEN_DEFAULT;
   localparam int EXPECT_DEPTH = 16;
   localparam int EXPECT_AW    = 4;

   logic signed [DW-1:0]       sample_mem [MAX_LEN];
   int unsigned                fill_level;
   logic [GROUP_LENGTH_W-1:0]  len_reg;
   logic [PERCENTILE_W-1:0]    q_reg;
   rounding_type               mode_reg;
   logic signed [DW-1:0]       expect_mem [EXPECT_DEPTH];
   logic [EXPECT_AW-1:0]       expect_rd;
   logic [EXPECT_AW-1:0]       expect_wr;
   int unsigned                expect_count;

   function automatic int unsigned percentile_rank(input int unsigned len);
      longint unsigned n;
      longint unsigned q;
      longint unsigned prod;
      longint unsigned off;
      n = len - 1;
      q = (q_reg > Q_FULL) ? Q_FULL : q_reg;
      prod = n * (Q_FULL - q);
      case (mode_reg)
         RND_LOWER:   off = (prod + Q_CEIL_BIAS) / Q_FULL;
         RND_HIGHER:  off = prod / Q_FULL;
         RND_NEAREST: off = (prod + Q_HALF) / Q_FULL;
         default:     off = 0;
      endcase
      if (off > n) off = n;
      return int'(n - off);
   endfunction

   function automatic logic signed [DW-1:0] ranked_sample(input int unsigned len,
                                                           input int unsigned rank);
      logic signed [DW-1:0] ordered [MAX_LEN];
      logic signed [DW-1:0] key;
      int unsigned          i;
      int unsigned          j;
      for (i = 0; i < len; i++) ordered[i] = sample_mem[i];
      for (i = 1; i < len; i++) begin
         key = ordered[i];
         j = i;
         while (j > 0 && ordered[j-1] > key) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = key;
      end
      return ordered[rank];
   endfunction

   always @(posedge clock) begin
      int unsigned          len;
      int unsigned          slot;
      logic signed [DW-1:0] want;
      if (reset) begin
         fill_level = 0;
         len_reg = GROUP_LENGTH_RESET;
         q_reg = PERCENTILE_RESET;
         mode_reg = RND_NEAREST;
         expect_rd = '0;
         expect_wr = '0;
         expect_count = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expect_count == 0) begin
               $error("percentile_value: expected no item, actual %0d", rsp_percentile_value);
               mismatch_count++;
            end else begin
               want = expect_mem[expect_rd];
               expect_rd = expect_rd + 1'b1;
               expect_count--;
               if (rsp_percentile_value !== want) begin
                  $error("percentile_value: expected %0d, actual %0d",
                         want, rsp_percentile_value);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GROUP_LENGTH:  len_reg = csr_write_data[GROUP_LENGTH_W-1:0];
               CSR_PERCENTILE_Q:  q_reg = csr_write_data[PERCENTILE_W-1:0];
               CSR_ROUNDING_MODE: mode_reg = rounding_type'(csr_write_data[ROUNDING_W-1:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            len = (len_reg == 0) ? 1 : (len_reg > MAX_LEN) ? MAX_LEN : len_reg;
            slot = (fill_level < len - 1) ? fill_level : len - 1;
            sample_mem[slot] = req_sample_value;
            if (slot < len - 1) begin
               fill_level = slot + 1;
            end else begin
               fill_level = 0;
               if (expect_count >= EXPECT_DEPTH) begin
                  $error("percentile_value: expected at most %0d waiting items, actual %0d",
                         EXPECT_DEPTH, expect_count + 1);
                  mismatch_count++;
               end else begin
                  expect_mem[expect_wr] = ranked_sample(len, percentile_rank(len));
                  expect_wr = expect_wr + 1'b1;
                  expect_count++;
               end
            end
         end
      end
      results_pending = int'(expect_count);
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import gpsel_pkg::*;

   localparam int DW             = DATA_WIDTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 150000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RANDOM_ITEMS   = 780;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [DW-1:0]   req_sample_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [DW-1:0]   rsp_percentile_value;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;
   int                     mismatch_count;
   int                     results_pending;
   int                     quiet_cycles = 0;
   logic                   steady_sender = 1'b0;

   group_percentile_select_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample_value     (req_sample_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_percentile_value (rsp_percentile_value),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   gpsel_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample_value     (req_sample_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_percentile_value (rsp_percentile_value),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .mismatch_count       (mismatch_count),
      .results_pending      (results_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin : receiver_stalls
      int unsigned roll;
      int unsigned span;
      forever begin
         roll = $urandom_range(0, 99);
         @(negedge clock);
         if (roll < 25) begin
            rsp_stall = 1'b1;
            span = $urandom_range(1, 3);
         end else if (roll < 32) begin
            rsp_stall = 1'b1;
            span = $urandom_range(10, 60);
         end else if (roll < 45) begin
            rsp_stall = 1'b0;
            span = $urandom_range(100, 400);
         end else begin
            rsp_stall = 1'b0;
            span = $urandom_range(1, 20);
         end
         repeat (span - 1) @(negedge clock);
      end
   end

   task automatic put_sample(input logic signed [DW-1:0] value);
      int unsigned roll;
      int unsigned gap;
      roll = $urandom_range(0, 99);
      if (steady_sender || roll < 60) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample_value = value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic put_group(input int unsigned count);
      int unsigned          i;
      int unsigned          roll;
      logic signed [DW-1:0] value;
      for (i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            case ($urandom_range(0, 4))
               0: value = 32'sh7FFFFFFF;
               1: value = 32'sh80000000;
               2: value = '0;
               3: value = '1;
               default: value = 1;
            endcase
         end else if (roll < 25) begin
            value = $urandom_range(0, 8) - 4;
         end else begin
            value = $urandom;
         end
         put_sample(value);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned data);
      drain();
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   initial begin
      int unsigned random_items;
      int unsigned groups;
      int unsigned g;
      int unsigned count;
      int unsigned group_size;
      int unsigned len_value;
      int unsigned roll;
      logic        write_len;
      logic        write_q;
      logic        write_mode;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset configuration is one sample per group.
      put_sample(32'sh7FFFFFFF);
      put_sample(32'sh80000000);
      put_sample('0);
      put_sample(-1);
      write_csr(CSR_NONE, 14'h3FFF);
      write_csr(CSR_GROUP_LENGTH, 0);
      put_sample(32'sh12345678);

      write_csr(CSR_GROUP_LENGTH, 4);
      write_csr(CSR_PERCENTILE_Q, 0);
      write_csr(CSR_ROUNDING_MODE, RND_LOWER);
      put_sample(32'sh80000000);
      put_sample(32'sh7FFFFFFF);
      put_sample(-1);
      put_sample('0);

      write_csr(CSR_PERCENTILE_Q, Q_FULL);
      write_csr(CSR_ROUNDING_MODE, RND_HIGHER);
      put_sample(5);
      put_sample(-5);
      put_sample(100);
      put_sample(-100);

      write_csr(CSR_PERCENTILE_Q, 14'h3FFF);
      write_csr(CSR_ROUNDING_MODE, RND_NEAREST);
      put_sample(7);
      put_sample(7);
      put_sample(-3);
      put_sample(9);

      write_csr(CSR_PERCENTILE_Q, 2500);
      write_csr(CSR_ROUNDING_MODE, RND_UNUSED);
      put_sample(11);
      put_sample(-11);
      put_sample(0);
      put_sample(3);

      // The length shrinks below the samples already held, so the next one ends the group.
      write_csr(CSR_GROUP_LENGTH, 5);
      write_csr(CSR_PERCENTILE_Q, Q_HALF);
      write_csr(CSR_ROUNDING_MODE, RND_NEAREST);
      put_sample(40);
      put_sample(-40);
      put_sample(2);
      write_csr(CSR_GROUP_LENGTH, 2);
      put_sample(1);

      // One group at the largest length, written above the maximum.
      write_csr(CSR_GROUP_LENGTH, 2047);
      write_csr(CSR_PERCENTILE_Q, $urandom_range(0, 10000));
      write_csr(CSR_ROUNDING_MODE, $urandom_range(0, 2));
      put_group(1024);

      write_csr(CSR_GROUP_LENGTH, 8);
      group_size = 8;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         steady_sender = ($urandom_range(0, 3) == 0);
         write_len = $urandom_range(0, 1);
         write_q = $urandom_range(0, 1);
         write_mode = $urandom_range(0, 1);
         if (!write_q && !write_mode) write_len = 1'b1;
         if (write_len) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) len_value = 0;
            else if (roll < 70) len_value = $urandom_range(1, 8);
            else if (roll < 90) len_value = $urandom_range(9, 24);
            else len_value = $urandom_range(25, 64);
            write_csr(CSR_GROUP_LENGTH, len_value);
            group_size = (len_value == 0) ? 1 : len_value;
         end
         if (write_q) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) write_csr(CSR_PERCENTILE_Q, 2500 * $urandom_range(0, 4));
            else if (roll < 22) write_csr(CSR_PERCENTILE_Q, $urandom_range(10001, 16383));
            else write_csr(CSR_PERCENTILE_Q, $urandom_range(0, 10000));
         end
         if (write_mode) begin
            if ($urandom_range(0, 99) < 8) write_csr(CSR_ROUNDING_MODE, RND_UNUSED);
            else write_csr(CSR_ROUNDING_MODE, $urandom_range(0, 2));
         end
         groups = $urandom_range(1, 5);
         for (g = 0; g < groups; g++) begin
            if ($urandom_range(0, 9) == 0) drain();
            count = group_size;
            if (g == groups - 1 && $urandom_range(0, 99) < 15) begin
               count = $urandom_range(0, group_size - 1);
            end
            put_group(count);
            random_items += count;
         end
      end

      steady_sender = 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/gpsel_pkg.sv
design/gpsel_ram.sv
design/group_percentile_select_unit.sv
tb/gpsel_checker.sv
tb/tb.sv
